FILE: design/mbc_pkg.sv
// Shared definitions for the multi-pin blink controller: sizes, command and
// register codes, sequencer states and the pin table entry layout.
// Depends on nothing; every other design file imports it.
package mbc_pkg;

    localparam int PIN_COUNT = 8;
    // Only eight pins have table storage and output bits.
    localparam int NPINS     = (PIN_COUNT < 8) ? PIN_COUNT : 8;
    localparam int PIN_AW    = (NPINS > 1) ? $clog2(NPINS) : 1;

    localparam int CMD_W     = 2;
    localparam int PIN_IDX_W = 3;
    localparam int TIME_W    = 32;
    localparam int REP_W     = 8;
    localparam int MASK_W    = 8;
    localparam int PERIOD_W  = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LEVELS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE         = 2'd2;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd10;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_DRIVE = 2'd1,
        CMD_BLINK = 2'd2,
        CMD_INIT  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_WALK,
        ST_BLINK_WR,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [TIME_W-1:0] time_ref;
        logic [TIME_W-1:0] interval;
        logic [REP_W-1:0]  rep_limit;
        logic [REP_W-1:0]  count;
    } pin_entry_t;

    typedef struct packed {
        logic              rd_en;
        logic [PIN_AW-1:0] rd_addr;
        logic              wr_en;
        logic [PIN_AW-1:0] wr_addr;
        pin_entry_t        wr_data;
        logic              clear_all;
    } ram_req_t;

    typedef struct packed {
        pin_entry_t entry;
        logic       write;
        logic       level;
    } pin_upd_t;

endpackage

FILE: design/multi_pin_blink_controller_top.sv
// Top level of the multi-pin blink controller: the sequencer and the pin
// table memory. Depends on mbc_pkg, mbc_pin_ram and mbc_ctrl.
//
// Usage: each input item carries a command (tick, drive pin, start blink,
// init all pins) with its pin index, level, interval and repeat count. Every
// accepted item yields exactly one result item with the levels of all pins
// and the mask of pins that are blinking. Configuration registers (active
// levels, process period, enable) are written through cfg_we, cfg_index and
// cfg_data while no item is in flight.
// From acceptance, drive and init go straight to the finish step, which
// registers the result; blink first passes the blink write step (read and
// write back of the pin entry), and a tick passes the tick step and, when
// a processing pass is due, walks the pin table, one entry per cycle through
// the single read and single write port of the table. in_ready returns high
// in the same cycle that the result is registered.
// Reset clears the tick counter, pass timing, pin levels and every table
// entry (through per-entry valid bits); it takes effect at once.
// A result waits in its output register while out_ready is low; the block
// may accept the next item meanwhile but holds its result until the
// previous one is taken.
module multi_pin_blink_controller_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [mbc_pkg::CMD_W-1:0]         cmd,
    input  logic [mbc_pkg::PIN_IDX_W-1:0]     pin_index,
    input  logic                              level,
    input  logic [mbc_pkg::TIME_W-1:0]        interval,
    input  logic [mbc_pkg::REP_W-1:0]         rep_count,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [mbc_pkg::MASK_W-1:0]        pin_levels,
    output logic [mbc_pkg::MASK_W-1:0]        blinking_mask,
    input  logic                              cfg_we,
    input  logic [mbc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mbc_pkg::CFG_W-1:0]         cfg_data
);
    import mbc_pkg::*;

    ram_req_t   ram_req;
    pin_entry_t rd_data;

    mbc_pin_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    mbc_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .pin_index     (pin_index),
        .level         (level),
        .interval      (interval),
        .rep_count     (rep_count),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pin_levels    (pin_levels),
        .blinking_mask (blinking_mask),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .ram_req       (ram_req),
        .rd_data       (rd_data)
    );

endmodule

FILE: design/mbc_pin_ram.sv
// Pin table memory: one entry per pin, synchronous read into an output
// register, and a valid bit per entry so that reset and init read as zero.
// Depends on mbc_pkg.
module mbc_pin_ram (
    input  logic                clk,
    input  logic                rst_n,
    input  mbc_pkg::ram_req_t   req,
    output mbc_pkg::pin_entry_t rd_data
);
    import mbc_pkg::*;

    pin_entry_t       mem [NPINS];
    logic [NPINS-1:0] valid_reg;
    pin_entry_t       rd_data_reg;
    logic             rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.clear_all)
            begin
                valid_reg <= '0;
            end
            else if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    // An entry never written since reset or init reads as all zero.
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

FILE: design/mbc_pin_update.sv
// Blink update for one pin: expiry test and the toggle, count or stop
// decision applied to an entry read from the pin table.
// Depends on mbc_pkg.
module mbc_pin_update (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mbc_pkg::pin_entry_t               entry,
    input  logic [mbc_pkg::TIME_W-1:0]        now,
    input  logic                              cur_level,
    input  logic                              idle_level,
    output mbc_pkg::pin_upd_t                 upd
);
    import mbc_pkg::*;

    logic [TIME_W-1:0] elapsed;

    assign elapsed = now - entry.time_ref;

    always_comb
    begin
        upd.entry = entry;
        upd.write = 1'b0;
        upd.level = cur_level;
        if ((entry.interval != '0) && (elapsed > entry.interval))
        begin
            upd.write = 1'b1;
            if (entry.rep_limit == '0)
            begin
                upd.level          = ~cur_level;
                upd.entry.time_ref = now;
            end
            else if (entry.count < entry.rep_limit)
            begin
                upd.level          = ~cur_level;
                upd.entry.time_ref = now;
                // A repetition is counted each time the pin returns to idle.
                if (~cur_level == idle_level)
                begin
                    upd.entry.count = entry.count + 1'b1;
                end
            end
            else
            begin
                upd.level          = idle_level;
                upd.entry.count    = '0;
                upd.entry.interval = '0;
            end
        end
    end

    // The update never starts a blink on a stopped pin.
    a_stopped_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (entry.interval == '0) |-> (upd.entry.interval == '0) && !upd.write)
        else $error("update touched a pin with a zero interval");

    // A stop always leaves the pin idle with a cleared count.
    a_stop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (upd.write && upd.entry.interval == '0) |->
            (upd.level == idle_level) && (upd.entry.count == '0))
        else $error("stopped pin not idle or count not cleared");

    // The time reference is refreshed on every toggle.
    a_toggle_ref: assert property (@(posedge clk) disable iff (!rst_n)
        (upd.level != cur_level && upd.entry.interval != '0) |->
            (upd.entry.time_ref == now))
        else $error("toggle without time reference refresh");

endmodule

FILE: design/mbc_ctrl.sv
// Sequencer of the blink controller: command decode, tick counter, pass
// timing, the walk over the pin table, pin levels and the result register.
// Depends on mbc_pkg and mbc_pin_update.
module mbc_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [mbc_pkg::CMD_W-1:0]           cmd,
    input  logic [mbc_pkg::PIN_IDX_W-1:0]       pin_index,
    input  logic                                level,
    input  logic [mbc_pkg::TIME_W-1:0]          interval,
    input  logic [mbc_pkg::REP_W-1:0]           rep_count,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [mbc_pkg::MASK_W-1:0]          pin_levels,
    output logic [mbc_pkg::MASK_W-1:0]          blinking_mask,
    input  logic                                cfg_we,
    input  logic [mbc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mbc_pkg::CFG_W-1:0]           cfg_data,
    output mbc_pkg::ram_req_t                   ram_req,
    input  mbc_pkg::pin_entry_t                 rd_data
);
    import mbc_pkg::*;

    state_t              state_reg, state_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [TIME_W-1:0]   last_pass_reg, last_pass_next;
    logic                armed_reg, armed_next;
    logic [NPINS-1:0]    levels_reg, levels_next;
    logic [NPINS-1:0]    mask_reg, mask_next;
    logic [NPINS-1:0]    active_levels_reg, active_levels_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic                enable_reg, enable_next;
    logic [PIN_AW-1:0]   walk_idx_reg, walk_idx_next;
    logic [PIN_AW-1:0]   blink_pin_reg, blink_pin_next;
    logic [TIME_W-1:0]   blink_ivl_reg, blink_ivl_next;
    logic [REP_W-1:0]    blink_rep_reg, blink_rep_next;
    logic                out_valid_reg, out_valid_next;
    logic [MASK_W-1:0]   pin_levels_reg, pin_levels_next;
    logic [MASK_W-1:0]   blinking_mask_reg, blinking_mask_next;

    logic [PIN_AW-1:0]   pin_addr;
    logic                pin_ok;
    logic [TIME_W-1:0]   pass_elapsed;
    pin_upd_t            upd;

    assign pin_addr     = pin_index[PIN_AW-1:0];
    assign pin_ok       = ({1'b0, pin_index} < (PIN_IDX_W + 1)'(NPINS));
    assign pass_elapsed = now_reg - last_pass_reg;

    mbc_pin_update u_update (
        .clk        (clk),
        .rst_n      (rst_n),
        .entry      (rd_data),
        .now        (now_reg),
        .cur_level  (levels_reg[walk_idx_reg]),
        .idle_level (~active_levels_reg[walk_idx_reg]),
        .upd        (upd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            now_reg           <= '0;
            last_pass_reg     <= '0;
            armed_reg         <= 1'b0;
            levels_reg        <= '0;
            mask_reg          <= '0;
            active_levels_reg <= '1;
            period_reg        <= PERIOD_RESET;
            enable_reg        <= 1'b0;
            walk_idx_reg      <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            now_reg           <= now_next;
            last_pass_reg     <= last_pass_next;
            armed_reg         <= armed_next;
            levels_reg        <= levels_next;
            mask_reg          <= mask_next;
            active_levels_reg <= active_levels_next;
            period_reg        <= period_next;
            enable_reg        <= enable_next;
            walk_idx_reg      <= walk_idx_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blink_pin_reg     <= blink_pin_next;
        blink_ivl_reg     <= blink_ivl_next;
        blink_rep_reg     <= blink_rep_next;
        pin_levels_reg    <= pin_levels_next;
        blinking_mask_reg <= blinking_mask_next;
    end

    always_comb
    begin
        state_next         = state_reg;
        now_next           = now_reg;
        last_pass_next     = last_pass_reg;
        armed_next         = armed_reg;
        levels_next        = levels_reg;
        mask_next          = mask_reg;
        active_levels_next = active_levels_reg;
        period_next        = period_reg;
        enable_next        = enable_reg;
        walk_idx_next      = walk_idx_reg;
        blink_pin_next     = blink_pin_reg;
        blink_ivl_next     = blink_ivl_reg;
        blink_rep_next     = blink_rep_reg;
        out_valid_next     = out_valid_reg;
        pin_levels_next    = pin_levels_reg;
        blinking_mask_next = blinking_mask_reg;
        ram_req            = '0;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_ACTIVE_LEVELS:  active_levels_next = cfg_data[NPINS-1:0];
                REG_PROCESS_PERIOD: period_next        = cfg_data;
                REG_ENABLE:         enable_next        = cfg_data[0];
                default:            ;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    blink_pin_next = pin_addr;
                    blink_ivl_next = interval;
                    blink_rep_next = rep_count;
                    state_next     = ST_FINISH;
                    case (cmd)
                        CMD_TICK:
                        begin
                            now_next   = now_reg + 1'b1;
                            state_next = ST_TICK;
                        end
                        CMD_DRIVE:
                        begin
                            if (pin_ok)
                            begin
                                levels_next[pin_addr] = level ? active_levels_reg[pin_addr]
                                                              : ~active_levels_reg[pin_addr];
                            end
                        end
                        CMD_BLINK:
                        begin
                            // The stored count is kept, so the entry is read first.
                            if (pin_ok)
                            begin
                                ram_req.rd_en   = 1'b1;
                                ram_req.rd_addr = pin_addr;
                                state_next      = ST_BLINK_WR;
                            end
                        end
                        CMD_INIT:
                        begin
                            levels_next       = ~active_levels_reg;
                            mask_next         = '0;
                            ram_req.clear_all = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_TICK:
            begin
                state_next = ST_FINISH;
                if (enable_reg && (pass_elapsed >= TIME_W'(period_reg)))
                begin
                    last_pass_next = now_reg;
                    if (!armed_reg)
                    begin
                        armed_next = 1'b1;
                    end
                    else
                    begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = '0;
                        walk_idx_next   = '0;
                        state_next      = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                // Entry walk_idx is written back while the next one is read.
                ram_req.wr_en           = upd.write;
                ram_req.wr_addr         = walk_idx_reg;
                ram_req.wr_data         = upd.entry;
                levels_next[walk_idx_reg] = upd.level;
                mask_next[walk_idx_reg]   = (upd.entry.interval != '0);
                if (walk_idx_reg == PIN_AW'(NPINS - 1))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = walk_idx_reg + 1'b1;
                    walk_idx_next   = walk_idx_reg + 1'b1;
                end
            end
            ST_BLINK_WR:
            begin
                ram_req.wr_en              = 1'b1;
                ram_req.wr_addr            = blink_pin_reg;
                ram_req.wr_data.time_ref   = now_reg;
                ram_req.wr_data.interval   = blink_ivl_reg;
                ram_req.wr_data.rep_limit  = blink_rep_reg;
                ram_req.wr_data.count      = rd_data.count;
                mask_next[blink_pin_reg]   = (blink_ivl_reg != '0);
                if (blink_ivl_reg == '0)
                begin
                    levels_next[blink_pin_reg] = ~active_levels_reg[blink_pin_reg];
                end
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next     = 1'b1;
                    pin_levels_next    = MASK_W'(levels_reg);
                    blinking_mask_next = MASK_W'(mask_reg);
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready      = (state_reg == ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign pin_levels    = pin_levels_reg;
    assign blinking_mask = blinking_mask_reg;

    a_tick_count: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && cmd == CMD_TICK) |=> (now_reg == $past(now_reg) + 1'b1))
        else $error("tick did not advance the counter by one");

    a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (walk_idx_reg <= PIN_AW'(NPINS - 1)))
        else $error("walk index beyond the pin table");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result loaded outside the finish step");

    a_init_clears_mask: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && cmd == CMD_INIT) |=> (mask_reg == '0))
        else $error("init left blinking pins");

    a_no_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_req.wr_en && ram_req.rd_en) |-> (ram_req.rd_addr != ram_req.wr_addr))
        else $error("read and write of the same pin entry in one cycle");

endmodule
